/* hdl/mbsp_pkg.sv */
`default_nettype none

package mbsp_pkg;

    // Default store depth for one system-exclusive message
    localparam int MAX_MSG_DEF = 64;

    // Byte codes
    localparam logic [7:0] BYTE_SOX  = 8'hF0;
    localparam logic [7:0] BYTE_EOX  = 8'hF7;
    localparam logic [7:0] BYTE_CLK  = 8'hF8;
    localparam logic [7:0] BYTE_STRT = 8'hFA;
    localparam logic [7:0] BYTE_CONT = 8'hFB;
    localparam logic [7:0] BYTE_STOP = 8'hFC;
    localparam logic [7:0] BYTE_SENS = 8'hFE;
    localparam logic [7:0] BYTE_RST  = 8'hFF;
    // Channel status groups
    localparam logic [2:0] GRP_TWO_BYTE = 3'b110;   // C0..DF
    localparam logic [3:0] NIB_SYSTEM   = 4'hF;

    // Message kind on the output tuser
    typedef enum logic [1:0] {
        KIND_RT = 2'd0,
        KIND_CH = 2'd1,
        KIND_SX = 2'd2
    } t_kind;

    // Datapath commands from the controller
    typedef struct packed {
        logic  take;    // input transfer: update parse state
        logic  rd;      // read store at emit index
        logic  load;    // load output register
        logic  inc;     // advance emit index
        t_kind src;     // output source and kind
    } t_ctl_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic emit_rt;  // incoming byte is real-time
        logic emit_ch;  // incoming byte completes a channel message
        logic emit_sx;  // incoming byte closes a sysex with end-of-exclusive
        logic out_free; // output register can take a byte this cycle
        logic last;     // emit index is on the final byte
    } t_dp_stat;

    function automatic logic is_realtime(input logic [7:0] b);
        return (b == BYTE_CLK) || (b == BYTE_STRT) || (b == BYTE_CONT) ||
               (b == BYTE_STOP) || (b == BYTE_SENS) || (b == BYTE_RST);
    endfunction

endpackage

`default_nettype wire

/* hdl/mbsp_datapath.sv */
`default_nettype none

module mbsp_datapath #(
    parameter int MAX_MSG = mbsp_pkg::MAX_MSG_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [7:0]          i_byte,
    input  wire mbsp_pkg::t_ctl_cmd  i_cmd,
    output mbsp_pkg::t_dp_stat       o_stat,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [7:0]               o_m_tdata,
    output logic                     o_m_tlast,
    output logic [1:0]               o_m_tuser
);

    localparam int AW    = $clog2(MAX_MSG);
    localparam int CNT_W = $clog2(MAX_MSG + 1);
    localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_MSG - 1);

    // Channel phase codes
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_D1   = 3'd1;
    localparam logic [2:0] PH_D2   = 3'd2;
    localparam logic [2:0] PH_FULL = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic [7:0]       r_store [MAX_MSG];
    logic [CNT_W-1:0] r_count, n_count;
    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_msg [3];
    logic [CNT_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_idx;
    logic [7:0]       r_byte;
    logic [7:0]       r_rd_data;
    logic             r_out_valid;
    logic [7:0]       r_out_data;
    logic             r_out_last;
    logic [1:0]       r_out_kind;

    logic       is_sox, is_rt, sx_act, sx_end, is_status;
    logic [2:0] ph_eff, ph_inc;
    logic       ch_data, ch_emit, msg_wr;
    logic [7:0] ch_byte, out_byte;
    logic       out_last;

    // Classify the incoming byte against the parse state
    always_comb begin
        is_sox    = (i_byte == mbsp_pkg::BYTE_SOX);
        is_rt     = mbsp_pkg::is_realtime(i_byte);
        is_status = i_byte[7];
        sx_act    = (r_count != '0);
        sx_end    = is_status || (r_count >= CNT_LIM);
        // running status: a data byte after a full message reuses the status
        if (r_phase == PH_DONE) begin
            ph_eff = is_status ? PH_IDLE : PH_D1;
        end else begin
            ph_eff = r_phase;
        end
        ph_inc  = ph_eff + 3'd1;
        ch_data = !is_status && ((ph_eff == PH_D1) || (ph_eff == PH_D2));
        ch_emit = ch_data &&
                  ((r_msg[0][7:5] == mbsp_pkg::GRP_TWO_BYTE) || (ph_inc == PH_FULL));
    end

    // Next parse state for one input transfer
    always_comb begin
        n_count = r_count;
        n_phase = r_phase;
        n_len   = r_len;
        msg_wr  = 1'b0;
        if (is_sox) begin
            n_count = CNT_W'(1);
            n_phase = PH_IDLE;
        end else if (is_rt) begin
            n_count = r_count;
        end else if (sx_act) begin
            n_count = sx_end ? '0 : r_count + CNT_W'(1);
            n_len   = r_count + CNT_W'(1);
        end else if (ch_data) begin
            msg_wr  = 1'b1;
            n_phase = ch_emit ? PH_DONE : ph_inc;
            n_len   = CNT_W'(ph_inc);
        end else if (is_status && (i_byte[7:4] != mbsp_pkg::NIB_SYSTEM)) begin
            n_phase = PH_D1;
        end else begin
            n_phase = PH_IDLE;
        end
    end

    assign o_stat.emit_rt  = is_rt;
    assign o_stat.emit_ch  = !is_sox && !is_rt && !sx_act && ch_emit;
    assign o_stat.emit_sx  = !is_sox && !is_rt && sx_act && (i_byte == mbsp_pkg::BYTE_EOX);
    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_stat.last     = (r_idx + CNT_W'(1) == r_len);

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= PH_IDLE;
            r_msg   <= '{default: '0};
        end else if (i_cmd.take) begin
            r_count <= n_count;
            r_phase <= n_phase;
            if (!is_sox && !is_rt && !sx_act) begin
                if (msg_wr) begin
                    r_msg[ph_eff[1:0]] <= i_byte;
                end else if (n_phase == PH_D1) begin
                    r_msg[0] <= i_byte;
                end
            end
        end
    end

    // Sysex store: written on input transfers, read during emission
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            if (is_sox) begin
                r_store[0] <= i_byte;
            end else if (!is_rt && sx_act) begin
                r_store[r_count[AW-1:0]] <= i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_store[r_idx[AW-1:0]];
        end
    end

    // Emission bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_byte <= i_byte;
            r_len  <= n_len;
            r_idx  <= '0;
        end else if (i_cmd.inc) begin
            r_idx  <= r_idx + CNT_W'(1);
        end
    end

    // Output source select
    always_comb begin
        case (r_idx[1:0])
            2'd0:    ch_byte = r_msg[0];
            2'd1:    ch_byte = r_msg[1];
            default: ch_byte = r_msg[2];
        endcase
        case (i_cmd.src)
            mbsp_pkg::KIND_RT: begin
                out_byte = r_byte;
                out_last = 1'b1;
            end
            mbsp_pkg::KIND_CH: begin
                out_byte = ch_byte;
                out_last = o_stat.last;
            end
            default: begin
                out_byte = r_rd_data;
                out_last = o_stat.last;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data <= out_byte;
            r_out_last <= out_last;
            r_out_kind <= i_cmd.src;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_kind;

endmodule

`default_nettype wire

/* hdl/mbsp_ctrl.sv */
`default_nettype none

module mbsp_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire mbsp_pkg::t_dp_stat  i_stat,
    output mbsp_pkg::t_ctl_cmd       o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RT_OUT = 5'b00010,
        ST_CH_OUT = 5'b00100,
        ST_SX_RD  = 5'b01000,
        ST_SX_OUT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '{take: 1'b0, rd: 1'b0, load: 1'b0, inc: 1'b0,
                       src: mbsp_pkg::KIND_RT};
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.take = i_s_tvalid;
                if (i_s_tvalid) begin
                    if (i_stat.emit_rt) begin
                        n_state = ST_RT_OUT;
                    end else if (i_stat.emit_ch) begin
                        n_state = ST_CH_OUT;
                    end else if (i_stat.emit_sx) begin
                        n_state = ST_SX_RD;
                    end
                end
            end
            ST_RT_OUT: begin
                o_cmd.src  = mbsp_pkg::KIND_RT;
                o_cmd.load = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CH_OUT: begin
                o_cmd.src  = mbsp_pkg::KIND_CH;
                o_cmd.load = i_stat.out_free;
                o_cmd.inc  = i_stat.out_free;
                if (i_stat.out_free && i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SX_RD: begin
                o_cmd.src = mbsp_pkg::KIND_SX;
                o_cmd.rd  = 1'b1;
                n_state   = ST_SX_OUT;
            end
            ST_SX_OUT: begin
                o_cmd.src  = mbsp_pkg::KIND_SX;
                o_cmd.load = i_stat.out_free;
                o_cmd.inc  = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = i_stat.last ? ST_IDLE : ST_SX_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* hdl/midi_byte_stream_parser.sv */
// Channel | Direction | Signals                         | Contents
// s       | in        | i_s_tvalid/o_s_tready/i_s_tdata | received MIDI byte
// m       | out       | o_m_tvalid/i_m_tready/o_m_tdata | message byte, tlast, kind in tuser
//
// A byte that completes no message is taken while the parser stays idle. A real-time byte
// is then loaded into the output register once it is free; a channel message loads its
// bytes (2 or 3) in turn. Each byte of a sysex message takes one store read and one output
// load, set by the single registered read port of the sysex store.
// Reset is synchronous, active low; the sysex store needs no clearing.
// A stalled output holds the byte; input stays blocked while a message is being emitted.
`default_nettype none

module midi_byte_stream_parser #(
    parameter int MAX_MSG = mbsp_pkg::MAX_MSG_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] rx_byte
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] msg_byte
    output logic            o_m_tlast,   // msg_last
    output logic [1:0]      o_m_tuser    // [1:0] msg_kind
);

    mbsp_pkg::t_ctl_cmd cmd;
    mbsp_pkg::t_dp_stat stat;

    mbsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mbsp_datapath #(
        .MAX_MSG (MAX_MSG)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_s_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

/* hdl/mbsp_checker.sv */
`default_nettype none

module mbsp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tvalid,
    input wire logic       o_s_tready,
    input wire logic [7:0] i_s_tdata,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_m_tlast,
    input wire logic [1:0] o_m_tuser
);

    // Stalled output byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output changed while stalled");

    // Kind is one of the three defined codes
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == mbsp_pkg::KIND_RT) ||
                       (o_m_tuser == mbsp_pkg::KIND_CH) ||
                       (o_m_tuser == mbsp_pkg::KIND_SX))
        else $error("undefined message kind");

    // Real-time messages are one system real-time byte
    a_rt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == mbsp_pkg::KIND_RT) |->
            o_m_tlast && (o_m_tdata[7:3] == 5'b11111))
        else $error("bad real-time message");

    // A real-time input transfer blocks the input while its byte is loaded
    a_rt_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && mbsp_pkg::is_realtime(i_s_tdata) |=> !o_s_tready)
        else $error("input not blocked after real-time byte");

    // Nothing leaves right after reset
    a_rst: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid out of reset");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

/* tb/midi_msg_checker.sv */
`default_nettype none

// Watches both streams of the MIDI parser, rebuilds the expected message
// bytes from every input transfer and compares each output transfer in order.
module midi_msg_checker
    import mbsp_pkg::*;
#(
    parameter int MAX_MSG = MAX_MSG_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,   // [7:0] msg_byte
    input  wire logic       i_m_tlast,   // msg_last
    input  wire logic [1:0] i_m_tuser,   // [1:0] msg_kind
    output int              o_err_count,
    output int              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Channel parse phases
    localparam logic [2:0] PH_IDLE  = 3'd0;   // awaiting status
    localparam logic [2:0] PH_DATA1 = 3'd1;
    localparam logic [2:0] PH_DATA2 = 3'd2;
    localparam logic [2:0] PH_DONE  = 3'd4;   // running status armed

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_kind      kind;
    } t_msg_byte;

    t_msg_byte  expected_msg_q [$];
    logic [7:0] sysex_buf [MAX_MSG];
    logic [6:0] sysex_len;
    logic [2:0] ch_phase;
    logic [7:0] ch_bytes [3];

    initial o_err_count = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        o_err_count++;
    endtask

    function automatic bit is_rt_byte(input logic [7:0] b);
        case (b)
            BYTE_CLK, BYTE_STRT, BYTE_CONT, BYTE_STOP, BYTE_SENS, BYTE_RST: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void push_msg_byte(input logic [7:0] d, input logic l, input t_kind k);
        t_msg_byte m;
        m.data = d;
        m.last = l;
        m.kind = k;
        expected_msg_q.push_back(m);
    endfunction

    // Advance the parse state by one received byte and queue what it completes
    function automatic void parse_rx_byte(input logic [7:0] b);
        int idx;
        int len;
        int i;
        if (b == BYTE_SOX) begin
            // start of exclusive also drops running status
            sysex_buf[0] = b;
            sysex_len = 7'd1;
            ch_phase = PH_IDLE;
            return;
        end
        if (is_rt_byte(b)) begin
            push_msg_byte(b, 1'b1, KIND_RT);
            return;
        end
        // sysex collection: any status or the length limit closes it
        if (sysex_len != '0) begin
            idx = int'(sysex_len);
            if (idx < MAX_MSG) sysex_buf[idx] = b;
            sysex_len = 7'(idx + 1);
            if (b[7] || idx + 1 >= MAX_MSG) begin
                if (b == BYTE_EOX) begin
                    len = (idx + 1 > MAX_MSG) ? MAX_MSG : idx + 1;
                    for (i = 0; i < len; i++) begin
                        push_msg_byte(sysex_buf[i], i == len - 1, KIND_SX);
                    end
                end
                sysex_len = '0;
            end
            return;
        end
        // running status: a data byte reopens the last message
        if (ch_phase == PH_DONE) begin
            ch_phase = b[7] ? PH_IDLE : PH_DATA1;
        end
        if (ch_phase == PH_DATA1 || ch_phase == PH_DATA2) begin
            if (b[7]) begin
                ch_phase = PH_IDLE;
            end else begin
                ch_bytes[ch_phase] = b;
                ch_phase = ch_phase + 3'd1;
                len = int'(ch_phase);
                if (ch_bytes[0][7:5] == GRP_TWO_BYTE || len == 3) begin
                    for (i = 0; i < len; i++) begin
                        push_msg_byte(ch_bytes[i], i == len - 1, KIND_CH);
                    end
                    ch_phase = PH_DONE;
                end
                return;
            end
        end
        // awaiting status; system bytes are ignored here
        ch_phase = PH_IDLE;
        if (b[7] && b[7:4] != NIB_SYSTEM) begin
            ch_bytes[0] = b;
            ch_phase = PH_DATA1;
        end
    endfunction

    task automatic check_msg_byte();
        t_msg_byte exp_b;
        if (expected_msg_q.size() == 0) begin
            report_mismatch($sformatf("unexpected output byte %h last %b kind %0d",
                                      i_m_tdata, i_m_tlast, i_m_tuser));
            return;
        end
        exp_b = expected_msg_q.pop_front();
        if (i_m_tdata !== exp_b.data || i_m_tlast !== exp_b.last ||
            i_m_tuser !== exp_b.kind) begin
            report_mismatch($sformatf("output byte %h last %b kind %0d, expected %h %b %0d",
                                      i_m_tdata, i_m_tlast, i_m_tuser,
                                      exp_b.data, exp_b.last, exp_b.kind));
        end
    endtask

    // Output transfer is checked before the input transfer of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sysex_len = '0;
            ch_phase = PH_IDLE;
            ch_bytes = '{default: 8'h00};
            expected_msg_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_msg_byte();
            if (i_s_tvalid && i_s_tready) parse_rx_byte(i_s_tdata);
        end
        o_outstanding <= expected_msg_q.size();
    end

endmodule

`default_nettype wire

/* tb/midi_byte_stream_parser_test.sv */
`default_nettype none

module midi_byte_stream_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbsp_pkg::*;

    localparam int ITEMS_PER_PHASE = 45;
    localparam int IDLE_PCT        = 56;
    localparam int LIGHT_PCT       = 6;
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 2 * MAX_MSG_DEF + 20;

    // Channel status codes (channel in the low nibble)
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_PROG     = 8'hC0;
    localparam logic [7:0] ST_PRESS    = 8'hD0;
    localparam logic [7:0] ST_BEND     = 8'hE0;
    // System common and undefined system codes
    localparam logic [7:0] SYS_MTC  = 8'hF1;
    localparam logic [7:0] SYS_SPP  = 8'hF2;
    localparam logic [7:0] SYS_SONG = 8'hF3;
    localparam logic [7:0] SYS_F4   = 8'hF4;
    localparam logic [7:0] SYS_F5   = 8'hF5;
    localparam logic [7:0] SYS_TUNE = 8'hF6;
    localparam logic [7:0] SYS_F9   = 8'hF9;
    localparam logic [7:0] SYS_FD   = 8'hFD;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tready = 1'b0;
    wire logic       s_tready;
    wire logic       m_tvalid;
    wire logic [7:0] m_tdata;
    wire logic       m_tlast;
    wire logic [1:0] m_tuser;

    int         err_count;
    int         outstanding;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    bit         hold_req = 1'b0;
    logic [7:0] rx_q [$];

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    midi_byte_stream_parser dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    midi_msg_checker msg_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .i_m_tuser     (m_tuser),
        .o_err_count   (err_count),
        .o_outstanding (outstanding)
    );

    // Receiver: random stalls, plus a long hold-off on request
    always begin
        @(posedge clk);
        if (hold_req) begin
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_req = 1'b0;
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: ends the run after too many cycles without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one byte, with random gaps ahead of it; returns after its transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_rt();
        case ($urandom_range(5))
            0:       return BYTE_CLK;
            1:       return BYTE_STRT;
            2:       return BYTE_CONT;
            3:       return BYTE_STOP;
            4:       return BYTE_SENS;
            default: return BYTE_RST;
        endcase
    endfunction

    function automatic logic [7:0] pick_sys_common();
        case ($urandom_range(8))
            0:       return SYS_MTC;
            1:       return SYS_SPP;
            2:       return SYS_SONG;
            3:       return SYS_F4;
            4:       return SYS_F5;
            5:       return SYS_TUNE;
            6:       return SYS_F9;
            7:       return SYS_FD;
            default: return BYTE_EOX;
        endcase
    endfunction

    function automatic logic [7:0] rand_data();
        return 8'($urandom_range(127));
    endfunction

    // Queue a byte, sometimes with a real-time byte slipped in ahead of it
    function automatic void queue_rx(input logic [7:0] b);
        if ($urandom_range(99) < 8) rx_q.push_back(pick_rt());
        rx_q.push_back(b);
    endfunction

    function automatic void queue_sysex(input int n_data);
        queue_rx(BYTE_SOX);
        repeat (n_data) queue_rx(rand_data());
    endfunction

    // One random burst: mostly well-formed messages, some broken ones and noise
    function automatic void plan_burst();
        logic [7:0] status;
        int         pick;
        int         n_data;
        pick = $urandom_range(99);
        if (pick < 35) begin
            status = {4'($urandom_range(8, 14)), 4'($urandom_range(15))};
            n_data = (status[7:5] == GRP_TWO_BYTE) ? 1 : 2;
            queue_rx(status);
            repeat ($urandom_range(1, 3) * n_data) queue_rx(rand_data());
        end else if (pick < 47) begin
            repeat ($urandom_range(1, 4)) queue_rx(rand_data());
        end else if (pick < 62) begin
            queue_sysex($urandom_range(0, 6));
            if ($urandom_range(3) != 0) queue_rx(BYTE_EOX);
            else queue_rx(8'($urandom_range(128, 255)));
        end else if (pick < 65) begin
            queue_sysex($urandom_range(MAX_MSG_DEF - 4, MAX_MSG_DEF - 1));
            queue_rx(BYTE_EOX);
        end else if (pick < 75) begin
            rx_q.push_back(pick_rt());
        end else if (pick < 85) begin
            rx_q.push_back(pick_sys_common());
        end else begin
            rx_q.push_back(8'($urandom()));
        end
    endfunction

    initial begin : stimulus
        int         ph;
        int         sent;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: data while idle, three- and two-byte messages, running status,
        // stray status, real-time inside sysex, sysex restart, sysex dropped by a
        // status, running status cleared by start of exclusive, system bytes
        rx_q = {8'h00,
                ST_NOTE_ON, 8'h3C, 8'h7F,
                ST_PROG | 8'h05, 8'h12, 8'h13,
                ST_BEND | 8'h03, ST_NOTE_OFF, 8'h07, 8'h64,
                BYTE_SOX, 8'h01, BYTE_SENS, BYTE_SOX, 8'h7F, BYTE_EOX,
                8'h22,
                ST_PRESS | 8'h0A, 8'h55, SYS_FD, 8'h56,
                BYTE_SOX, 8'h10, ST_NOTE_ON, 8'h11,
                BYTE_RST, BYTE_EOX};
        while (rx_q.size() > 0) send_byte(rx_q.pop_front());

        // Random phases with different idling on both sides
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                    // longest sysex while the receiver holds off
                    hold_req = 1'b1;
                    queue_sysex(MAX_MSG_DEF - 2);
                    queue_rx(BYTE_EOX);
                end
                1: begin
                    src_idle_pct = IDLE_PCT;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = IDLE_PCT;
                end
                default: begin
                    src_idle_pct = LIGHT_PCT;
                    sink_stall_pct = LIGHT_PCT;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (rx_q.size() == 0) plan_burst();
                while (rx_q.size() > 0) begin
                    send_byte(rx_q.pop_front());
                    sent++;
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every expected byte, then let the block settle
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* midi_byte_stream_parser.f */
hdl/mbsp_pkg.sv
hdl/mbsp_datapath.sv
hdl/mbsp_ctrl.sv
hdl/midi_byte_stream_parser.sv
hdl/mbsp_checker.sv
tb/midi_msg_checker.sv
tb/midi_byte_stream_parser_test.sv
